// File: sv/touch_sample_filter_and_events_top_defines.svh
// Assertion macros shared by the touch filter RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef TOUCH_SAMPLE_FILTER_AND_EVENTS_TOP_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_AND_EVENTS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tsfe_pkg.sv
// Package for the touch sample filter: payload structs, codes, constants, FSM types.
// No dependencies; used by every module of the block.
`default_nettype none

package tsfe_pkg;

    // Field widths
    localparam int POS_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W    = 2;

    // Shared divider: 24-bit dividend covers a 12x12 scaling product
    localparam int DIV_W = 2 * POS_W;
    localparam int DVS_W = POS_W;

    // Defaults and fixed screen geometry
    localparam int SAMPLE_COUNT_DEF = 6;
    localparam int SCREEN_WIDTH     = 320;
    localparam int SCREEN_HEIGHT    = 240;
    localparam int MOVE_DEADBAND    = 8;

    // Request opcodes
    localparam logic OPC_SAMPLE = 1'b0;
    localparam logic OPC_POLL   = 1'b1;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] EV_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] EV_UP   = 2'd2;
    localparam logic [KIND_W-1:0] EV_CAL  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MODE = 3'd5;

    typedef struct packed {
        logic             opcode;
        logic             pen_down;
        logic [POS_W-1:0] raw_x;
        logic [POS_W-1:0] raw_y;
    } t_in_req;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } t_out_req;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_sample;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_MEAN_X,
        OP_MEAN_Y,
        OP_MAP_X,
        OP_MAP_Y
    } t_op;

endpackage

`default_nettype wire

// File: sv/touch_sample_filter_and_events_top.sv
// Channel   | Dir | Handshake                 | Payload
// --------- | --- | ------------------------- | -------------------------------------
// in        | in  | i_in_valid / o_in_stall   | i_in_req  (opcode, pen_down, raw x/y)
// out       | out | o_out_valid / i_out_stall | o_out_req (event_kind, pos_x, pos_y)
// cfg       | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A pen-up poll waits for any output stall. A pen-down poll runs a store scan, then two
// averages and, outside calibration mode, up to two axis scalings on the shared 24-step
// divider. Input stall is high whenever the sequencer is not idle.
// Reset is synchronous, active low; the sample store is not cleared.
// A result waits in the output register while the output is stalled.
`default_nettype none

`include "touch_sample_filter_and_events_top_defines.svh"

module touch_sample_filter_and_events_top #(
    parameter int SAMPLE_COUNT = tsfe_pkg::SAMPLE_COUNT_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  tsfe_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output tsfe_pkg::t_out_req                 o_out_req,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [tsfe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [tsfe_pkg::POS_W-1:0]         i_cfg_data
);

    localparam int POS_W  = tsfe_pkg::POS_W;
    localparam int DIV_W  = tsfe_pkg::DIV_W;
    localparam int DVS_W  = tsfe_pkg::DVS_W;
    localparam int ADDR_W = $clog2(SAMPLE_COUNT);
    localparam int FILL_W = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_W  = $clog2((SAMPLE_COUNT - 1) * ((1 << POS_W) - 1) + 1);
    localparam int DIFF_W = POS_W + 1;

    localparam logic [POS_W-1:0]  SCR_W   = POS_W'(tsfe_pkg::SCREEN_WIDTH);
    localparam logic [POS_W-1:0]  SCR_H   = POS_W'(tsfe_pkg::SCREEN_HEIGHT);
    localparam logic [DIFF_W-1:0] DB_LIM  = DIFF_W'(tsfe_pkg::MOVE_DEADBAND);
    localparam logic [DVS_W-1:0]  MEAN_DV = DVS_W'(SAMPLE_COUNT - 3);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SAMPLE_COUNT);

    // Configuration registers
    logic [POS_W-1:0] r_cal_x_lo, r_cal_x_hi, r_cal_y_lo, r_cal_y_hi;
    logic             r_swap, r_cal;

    // Sequencer and tracking state
    tsfe_pkg::t_state r_state, n_state;
    tsfe_pkg::t_op    r_op;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic              r_rd_vld;
    logic              r_pen_held;
    logic              r_was_held;
    logic [POS_W-1:0]  r_last_x, r_last_y;
    logic [POS_W-1:0]  r_rep_x, r_rep_y;

    // Scan accumulators and results
    logic [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic [POS_W-1:0]  r_min_x, r_min_y, r_max_x, r_max_y;
    logic [POS_W-1:0]  r_mean_x, r_mean_y;
    logic [POS_W-1:0]  r_pos_x, r_pos_y;
    logic [DIV_W-1:0]  r_dividend;
    logic [DVS_W-1:0]  r_divisor;
    logic [tsfe_pkg::KIND_W-1:0] r_kind;

    // Output register
    logic               r_out_valid;
    tsfe_pkg::t_out_req r_out_req;

    // Handshake and unit signals
    logic              in_acc;
    logic              cfg_acc;
    logic              out_free;
    logic              out_load;
    logic              div_start;
    logic              scan_issue;
    logic              st_wr_en;
    tsfe_pkg::t_sample st_wr_data;
    tsfe_pkg::t_sample st_rd_data;
    logic [DIV_W-1:0]  div_quot;
    tsfe_pkg::t_div_stat div_stat;

    // Axis scaling operands
    logic              map_is_x;
    logic [POS_W-1:0]  map_avg, map_lo, map_hi, map_w;
    logic              map_eq, map_gt, map_skip;
    logic [DIFF_W-1:0] map_diff;
    logic [POS_W-1:0]  map_span;
    logic [DIV_W-1:0]  map_prod;
    logic [POS_W-1:0]  map_pass;
    logic [POS_W-1:0]  map_clamp;

    // Trimmed sums and deadband test
    logic [SUM_W-1:0]  mean_num_x, mean_num_y;
    logic [DIFF_W-1:0] dx, dy, adx, ady;
    logic              in_band;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_x_lo <= '0;
            r_cal_x_hi <= '1;
            r_cal_y_lo <= '0;
            r_cal_y_hi <= '1;
            r_swap     <= 1'b0;
            r_cal      <= 1'b0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                tsfe_pkg::CFG_CAL_X_LO: r_cal_x_lo <= i_cfg_data;
                tsfe_pkg::CFG_CAL_X_HI: r_cal_x_hi <= i_cfg_data;
                tsfe_pkg::CFG_CAL_Y_LO: r_cal_y_lo <= i_cfg_data;
                tsfe_pkg::CFG_CAL_Y_HI: r_cal_y_hi <= i_cfg_data;
                tsfe_pkg::CFG_SWAP:     r_swap     <= i_cfg_data[0];
                tsfe_pkg::CFG_CAL_MODE: r_cal      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sample store
    assign st_wr_en     = in_acc && (i_in_req.opcode == tsfe_pkg::OPC_SAMPLE)
                          && (r_fill < FILL_MAX);
    assign st_wr_data.x = i_in_req.raw_x;
    assign st_wr_data.y = i_in_req.raw_y;

    tsfe_store #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_fill[ADDR_W-1:0]),
        .i_wr_data (st_wr_data),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (st_rd_data)
    );

    // Shared divider
    tsfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // Trimmed sums: drop min and max of the scanned entries
    assign mean_num_x = r_sum_x - SUM_W'(r_min_x) - SUM_W'(r_max_x);
    assign mean_num_y = r_sum_y - SUM_W'(r_min_y) - SUM_W'(r_max_y);

    // Axis scaling operands for the current step
    always_comb begin
        map_is_x = (r_op == tsfe_pkg::OP_MAP_X);
        if (map_is_x) begin
            map_avg = r_swap ? r_mean_y : r_mean_x;
            map_lo  = r_cal_x_lo;
            map_hi  = r_cal_x_hi;
            map_w   = SCR_W;
        end else begin
            map_avg = r_swap ? r_mean_x : r_mean_y;
            map_lo  = r_cal_y_lo;
            map_hi  = r_cal_y_hi;
            map_w   = SCR_H;
        end
        map_eq   = (map_hi == map_lo);
        map_gt   = (map_hi > map_lo);
        map_diff = map_gt ? ({1'b0, map_avg} - {1'b0, map_lo})
                          : ({1'b0, map_lo} - {1'b0, map_avg});
        map_span = map_gt ? (map_hi - map_lo) : (map_lo - map_hi);
        map_prod = map_diff[POS_W-1:0] * map_w;
        map_skip = map_eq || map_diff[DIFF_W-1];
        // Equal span passes the average (above map_w, map_w - 1); a negative offset clamps to zero
        if (map_eq) begin
            map_pass = (map_avg > map_w) ? (map_w - POS_W'(1)) : map_avg;
        end else begin
            map_pass = '0;
        end
        map_clamp = (div_quot > DIV_W'(map_w)) ? (map_w - POS_W'(1)) : div_quot[POS_W-1:0];
    end

    // Deadband test against the last reported position
    always_comb begin
        dx      = {1'b0, r_rep_x} - {1'b0, r_pos_x};
        dy      = {1'b0, r_rep_y} - {1'b0, r_pos_y};
        adx     = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
        ady     = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
        in_band = (adx < DB_LIM) && (ady < DB_LIM);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsfe_pkg::ST_IDLE: begin
                if (in_acc && (i_in_req.opcode == tsfe_pkg::OPC_POLL)) begin
                    if (i_in_req.pen_down) begin
                        n_state = tsfe_pkg::ST_SCAN;
                    end else if (r_pen_held) begin
                        n_state = tsfe_pkg::ST_EMIT;
                    end
                end
            end
            tsfe_pkg::ST_SCAN: begin
                if (r_idx == FILL_MAX) begin
                    n_state = tsfe_pkg::ST_PREP;
                end
            end
            tsfe_pkg::ST_PREP: begin
                if ((r_op == tsfe_pkg::OP_MAP_X || r_op == tsfe_pkg::OP_MAP_Y) && map_skip) begin
                    n_state = map_is_x ? tsfe_pkg::ST_PREP : tsfe_pkg::ST_DECIDE;
                end else begin
                    n_state = tsfe_pkg::ST_DIV_GO;
                end
            end
            tsfe_pkg::ST_DIV_GO: begin
                n_state = tsfe_pkg::ST_DIV_WAIT;
            end
            tsfe_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    case (r_op)
                        tsfe_pkg::OP_MEAN_X: n_state = tsfe_pkg::ST_PREP;
                        tsfe_pkg::OP_MEAN_Y: n_state = r_cal ? tsfe_pkg::ST_DECIDE
                                                             : tsfe_pkg::ST_PREP;
                        tsfe_pkg::OP_MAP_X:  n_state = tsfe_pkg::ST_PREP;
                        default:             n_state = tsfe_pkg::ST_DECIDE;
                    endcase
                end
            end
            tsfe_pkg::ST_DECIDE: begin
                if (r_cal || (r_was_held && in_band)) begin
                    n_state = tsfe_pkg::ST_IDLE;
                end else begin
                    n_state = tsfe_pkg::ST_EMIT;
                end
            end
            tsfe_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = tsfe_pkg::ST_IDLE;
                end
            end
            default: n_state = tsfe_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = (r_state != tsfe_pkg::ST_IDLE);
        div_start  = (r_state == tsfe_pkg::ST_DIV_GO);
        scan_issue = (r_state == tsfe_pkg::ST_SCAN) && (r_idx < FILL_MAX);
        out_load   = (r_state == tsfe_pkg::ST_EMIT) && out_free;
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tsfe_pkg::ST_IDLE;
            r_op       <= tsfe_pkg::OP_MEAN_X;
            r_fill     <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_pen_held <= 1'b0;
            r_was_held <= 1'b0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_rep_x    <= '0;
            r_rep_y    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_issue;
            if (scan_issue) begin
                r_idx <= r_idx + FILL_W'(1);
            end
            case (r_state)
                tsfe_pkg::ST_IDLE: begin
                    if (st_wr_en) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    if (in_acc && (i_in_req.opcode == tsfe_pkg::OPC_POLL)) begin
                        r_fill     <= '0;
                        r_idx      <= FILL_W'(1);
                        r_op       <= tsfe_pkg::OP_MEAN_X;
                        r_was_held <= r_pen_held;
                        if (!i_in_req.pen_down) begin
                            r_pen_held <= 1'b0;
                        end
                    end
                end
                tsfe_pkg::ST_PREP: begin
                    // A skipped scaling step advances straight to the next axis
                    if (r_op == tsfe_pkg::OP_MAP_X && map_skip) begin
                        r_op <= tsfe_pkg::OP_MAP_Y;
                    end
                end
                tsfe_pkg::ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        case (r_op)
                            tsfe_pkg::OP_MEAN_X: r_op <= tsfe_pkg::OP_MEAN_Y;
                            tsfe_pkg::OP_MEAN_Y: r_op <= tsfe_pkg::OP_MAP_X;
                            tsfe_pkg::OP_MAP_X:  r_op <= tsfe_pkg::OP_MAP_Y;
                            default:             r_op <= r_op;
                        endcase
                    end
                end
                tsfe_pkg::ST_DECIDE: begin
                    r_last_x   <= r_pos_x;
                    r_last_y   <= r_pos_y;
                    r_pen_held <= 1'b1;
                    if (!r_was_held || !in_band) begin
                        r_rep_x <= r_pos_x;
                        r_rep_y <= r_pos_y;
                    end
                end
                default: ;
            endcase
        end
    end

    // Scan accumulation and arithmetic payload
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_req.opcode == tsfe_pkg::OPC_POLL)) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_min_x <= '1;
            r_min_y <= '1;
            r_max_x <= '0;
            r_max_y <= '0;
            r_kind  <= r_cal ? tsfe_pkg::EV_CAL : tsfe_pkg::EV_UP;
        end else if (r_rd_vld) begin
            r_sum_x <= r_sum_x + SUM_W'(st_rd_data.x);
            r_sum_y <= r_sum_y + SUM_W'(st_rd_data.y);
            if (st_rd_data.x < r_min_x) r_min_x <= st_rd_data.x;
            if (st_rd_data.y < r_min_y) r_min_y <= st_rd_data.y;
            if (st_rd_data.x > r_max_x) r_max_x <= st_rd_data.x;
            if (st_rd_data.y > r_max_y) r_max_y <= st_rd_data.y;
        end

        // Load divider operands
        if (r_state == tsfe_pkg::ST_PREP) begin
            case (r_op)
                tsfe_pkg::OP_MEAN_X: begin
                    r_dividend <= DIV_W'(mean_num_x);
                    r_divisor  <= MEAN_DV;
                end
                tsfe_pkg::OP_MEAN_Y: begin
                    r_dividend <= DIV_W'(mean_num_y);
                    r_divisor  <= MEAN_DV;
                end
                default: begin
                    r_dividend <= map_prod;
                    r_divisor  <= map_span;
                    if (map_skip) begin
                        if (map_is_x) r_pos_x <= map_pass;
                        else          r_pos_y <= map_pass;
                    end
                end
            endcase
        end

        // Collect quotients
        if (r_state == tsfe_pkg::ST_DIV_WAIT && div_stat.done) begin
            case (r_op)
                tsfe_pkg::OP_MEAN_X: r_mean_x <= div_quot[POS_W-1:0];
                tsfe_pkg::OP_MEAN_Y: begin
                    r_mean_y <= div_quot[POS_W-1:0];
                    r_pos_x  <= r_mean_x;
                    r_pos_y  <= div_quot[POS_W-1:0];
                end
                tsfe_pkg::OP_MAP_X:  r_pos_x <= map_clamp;
                default:             r_pos_y <= map_clamp;
            endcase
        end

        if (r_state == tsfe_pkg::ST_DECIDE) begin
            r_kind <= r_was_held ? tsfe_pkg::EV_MOVE : tsfe_pkg::EV_DOWN;
        end
    end

    // Output register; every event carries the last decided position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_req.event_kind <= r_kind;
            r_out_req.pos_x      <= r_last_x;
            r_out_req.pos_y      <= r_last_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;
    assign o_cfg_ready = 1'b1;

    `TSFE_ASSERT_IMPL(a_div_start_idle, i_clk, i_rst_n, (r_state == tsfe_pkg::ST_DIV_GO), !div_stat.busy, "divider started while busy")
    `TSFE_ASSERT_NEXT(a_poll_down_scan, i_clk, i_rst_n, (in_acc && i_in_req.opcode == tsfe_pkg::OPC_POLL && i_in_req.pen_down), (r_state == tsfe_pkg::ST_SCAN), "pen-down poll did not start a scan")
    `TSFE_ASSERT_NEXT(a_poll_clears_fill, i_clk, i_rst_n, (in_acc && i_in_req.opcode == tsfe_pkg::OPC_POLL), (r_fill == '0), "poll left the sample fill count set")
    `TSFE_ASSERT_NEXT(a_emit_waits, i_clk, i_rst_n, (r_state == tsfe_pkg::ST_EMIT && r_out_valid && i_out_stall), (r_state == tsfe_pkg::ST_EMIT), "result dropped while output stalled")

endmodule

`default_nettype wire

// File: sv/tsfe_store.sv
// Raw sample store: one write port, one registered read port, x and y side by side.
// Depends on tsfe_pkg for the sample pair type.
`default_nettype none

module tsfe_store #(
    parameter int SAMPLE_COUNT = tsfe_pkg::SAMPLE_COUNT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_wr_en,
    input  wire  [$clog2(SAMPLE_COUNT)-1:0] i_wr_addr,
    input  tsfe_pkg::t_sample              i_wr_data,
    input  wire  [$clog2(SAMPLE_COUNT)-1:0] i_rd_addr,
    output tsfe_pkg::t_sample              o_rd_data
);

    tsfe_pkg::t_sample r_mem [SAMPLE_COUNT];
    tsfe_pkg::t_sample r_rd_data;

    // Write one pair per request
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/tsfe_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tsfe_pkg for widths and the status struct; uses the assertion macro header.
`default_nettype none

`include "touch_sample_filter_and_events_top_defines.svh"

module tsfe_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire  [tsfe_pkg::DIV_W-1:0]     i_dividend,
    input  wire  [tsfe_pkg::DVS_W-1:0]     i_divisor,
    output logic [tsfe_pkg::DIV_W-1:0]     o_quot,
    output tsfe_pkg::t_div_stat            o_stat
);

    localparam int DIV_W = tsfe_pkg::DIV_W;
    localparam int DVS_W = tsfe_pkg::DVS_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic             rem_ge;
    logic [DVS_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quot;

    // One trial subtraction per cycle
    always_comb begin
        rem_sh = {r_rem, r_quot[DIV_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_dvs});
        n_rem  = rem_ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : DVS_W'(rem_sh);
        n_quot = {r_quot[DIV_W-2:0], rem_ge};
    end

    // Control: count the steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `TSFE_ASSERT_NEXT(a_div_done_pulse, i_clk, i_rst_n, r_done, !r_done, "divider done lasted more than one cycle")
    `TSFE_ASSERT_IMPL(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while still busy")

endmodule

`default_nettype wire
